// File: sv/grs_pkg.sv
// Package for the gradient reflection shading block.
// Holds field widths, register indexes, the shade limit and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package grs_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	localparam int PIX_W    = 13;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int CFG_W    = 13;
	localparam int SHADE_W  = 8;

	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd512;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd512;

	localparam logic [35:0] SHADE_LIMIT = 36'd260100;
	localparam logic [19:0] SUM_CLAMP   = 20'd260101;
	localparam logic [13:0] MAG_LIMIT   = 14'd510;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_POS  = 7'b0000010,
		ST_DIFF = 7'b0000100,
		ST_SQX  = 7'b0001000,
		ST_SQY  = 7'b0010000,
		ST_SRCH = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

endpackage

// File: sv/gradient_reflection_shading.sv
// Top level of the gradient reflection shading block.
// Line stores, position counters, gradient and an iterative root search on one multiplier.
// Depends on grs_pkg.
`timescale 1ns / 1ps

// Pixels arrive one word at a time in raster order and the block shades the pixel one row
// up and one column left of each arriving pixel, giving no word for border pixels. An
// accepted pixel keeps the input stalled through the POS and DIFF states, and a pixel
// that yields a shade also through SQX, SQY, the eight-step bitwise search and DONE. The
// search runs one step a cycle on the single shared multiplier after the SQX and SQY
// states square the gradients on the same multiplier. The output register lets the
// next pixel be accepted while a shade still waits to be taken; a finished shade that
// finds the previous one still waiting holds the input stalled until that one is taken.
// The user must write width and height only while the block is idle; the block itself
// does not enforce this. The two line stores need no clearing after reset.
module gradient_reflection_shading #(
	parameter int MAX_WIDTH = grs_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic                          cfg_index,
	input  logic [grs_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  logic signed [grs_pkg::PIX_W-1:0] pixel_value,
	input  logic                          frame_start,
	output logic                          shade_valid,
	input  logic                          shade_stall,
	output logic [grs_pkg::SHADE_W-1:0]   shade,
	output logic                          is_last
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH + 1);

	grs_pkg::state_t state_q;

	logic [grs_pkg::WIDTH_W-1:0]  width_q;
	logic [grs_pkg::HEIGHT_W-1:0] height_q;

	logic signed [grs_pkg::PIX_W-1:0] pix_q;
	logic                             fs_q;
	logic [CW-1:0]                    col_q;
	logic [grs_pkg::HEIGHT_W-1:0]     row_q;
	logic [AW-1:0]                    addr_q;
	logic                             interior_q;
	logic                             last_q;

	logic signed [grs_pkg::PIX_W-1:0] prev_mem [MAX_WIDTH];
	logic signed [grs_pkg::PIX_W-1:0] older_mem [MAX_WIDTH];
	logic signed [grs_pkg::PIX_W-1:0] prev_rd_q;
	logic signed [grs_pkg::PIX_W-1:0] older_rd_q;

	logic signed [grs_pkg::PIX_W-1:0] a1_q;
	logic signed [grs_pkg::PIX_W-1:0] a2_q;
	logic signed [grs_pkg::PIX_W-1:0] o1_q;
	logic signed [grs_pkg::PIX_W-1:0] prevpix_q;

	logic [8:0]  mx_q;
	logic [8:0]  my_q;
	logic        big_q;
	logic [17:0] sx_q;
	logic [19:0] sum_q;
	logic [7:0]  k_q;
	logic [15:0] k2_q;
	logic [2:0]  bit_q;

	logic [grs_pkg::SHADE_W-1:0] shade_q;
	logic                        last_out_q;
	logic                        valid_out_q;

	logic [13:0] w_eff;
	logic [13:0] h_eff;
	logic [13:0] col_a;
	logic [13:0] row_a;
	logic [13:0] col_n;
	logic [13:0] row_n;
	logic [AW-1:0] pos_addr;

	logic signed [13:0] tx;
	logic signed [13:0] ty;
	logic [13:0] mag_x;
	logic [13:0] mag_y;

	logic [19:0] mul_a;
	logic [15:0] mul_b;
	logic [35:0] mul_p;
	logic [16:0] cand;
	logic [19:0] sum_w;
	logic        out_free;

	always_comb begin
		w_eff = 14'(width_q);
		if (w_eff < 14'd3) begin
			w_eff = 14'd3;
		end
		if (w_eff > 14'(MAX_WIDTH)) begin
			w_eff = 14'(MAX_WIDTH);
		end
		h_eff = 14'(height_q);
		if (h_eff < 14'd3) begin
			h_eff = 14'd3;
		end
	end

	always_comb begin
		col_a = fs_q ? 14'd0 : 14'(col_q);
		row_a = fs_q ? 14'd0 : 14'(row_q);
		if (row_a >= h_eff) begin
			row_a = 14'd0;
		end
		if (col_a >= w_eff) begin
			col_a = 14'd0;
			row_a = row_a + 14'd1;
			if (row_a >= h_eff) begin
				row_a = 14'd0;
			end
		end
		col_n = col_a + 14'd1;
		row_n = row_a;
		if (col_n >= w_eff) begin
			col_n = 14'd0;
			row_n = row_a + 14'd1;
			if (row_n >= h_eff) begin
				row_n = 14'd0;
			end
		end
		pos_addr = col_a[AW-1:0];
	end

	always_comb begin
		tx = 14'(a2_q) - 14'(prev_rd_q);
		ty = 14'(o1_q) - 14'(prevpix_q);
		mag_x = tx[13] ? 14'(-tx) : 14'(tx);
		mag_y = ty[13] ? 14'(-ty) : 14'(ty);
	end

	always_comb begin
		cand = 17'(k2_q) + (17'(k_q) << (4'(bit_q) + 4'd1)) + (17'd1 << {bit_q, 1'b0});
		unique case (state_q)
			grs_pkg::ST_SQX: begin
				mul_a = 20'(mx_q);
				mul_b = 16'(mx_q);
			end
			grs_pkg::ST_SQY: begin
				mul_a = 20'(my_q);
				mul_b = 16'(my_q);
			end
			grs_pkg::ST_SRCH: begin
				mul_a = sum_q;
				mul_b = cand[15:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = 36'(mul_a) * 36'(mul_b);
		sum_w = 20'(sx_q) + mul_p[19:0] + 20'd4;
	end

	assign out_free    = !valid_out_q || !shade_stall;
	assign pixel_stall = (state_q != grs_pkg::ST_IDLE);
	assign shade_valid = valid_out_q;
	assign shade       = shade_q;
	assign is_last     = last_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= grs_pkg::WIDTH_RESET;
			height_q <= grs_pkg::HEIGHT_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				grs_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data[grs_pkg::WIDTH_W-1:0];
				grs_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data[grs_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == grs_pkg::ST_POS) begin
			prev_rd_q          <= prev_mem[pos_addr];
			prev_mem[pos_addr] <= pix_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == grs_pkg::ST_POS) begin
			older_rd_q <= older_mem[pos_addr];
		end
		if (state_q == grs_pkg::ST_DIFF) begin
			older_mem[addr_q] <= prev_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			grs_pkg::ST_IDLE: begin
				pix_q <= pixel_value;
				fs_q  <= frame_start;
			end
			grs_pkg::ST_POS: begin
				addr_q     <= pos_addr;
				interior_q <= (row_a >= 14'd2) && (col_a >= 14'd2);
				last_q     <= (row_a == h_eff - 14'd1) && (col_a == w_eff - 14'd1);
			end
			grs_pkg::ST_DIFF: begin
				a2_q  <= a1_q;
				a1_q  <= prev_rd_q;
				o1_q  <= older_rd_q;
				mx_q  <= mag_x[8:0];
				my_q  <= mag_y[8:0];
				big_q <= (mag_x >= grs_pkg::MAG_LIMIT) || (mag_y >= grs_pkg::MAG_LIMIT);
				k_q   <= '0;
				k2_q  <= '0;
				bit_q <= 3'd7;
			end
			grs_pkg::ST_SQX: begin
				sx_q <= mul_p[17:0];
			end
			grs_pkg::ST_SQY: begin
				sum_q <= big_q ? grs_pkg::SUM_CLAMP : sum_w;
			end
			grs_pkg::ST_SRCH: begin
				if (mul_p <= grs_pkg::SHADE_LIMIT) begin
					k_q  <= k_q | (8'd1 << bit_q);
					k2_q <= cand[15:0];
				end
				bit_q <= bit_q - 3'd1;
			end
			grs_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= grs_pkg::ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			prevpix_q   <= '0;
			valid_out_q <= 1'b0;
		end else begin
			if (valid_out_q && !shade_stall && state_q != grs_pkg::ST_DONE) begin
				valid_out_q <= 1'b0;
			end
			unique case (state_q)
				grs_pkg::ST_IDLE: begin
					if (pixel_valid) begin
						state_q <= grs_pkg::ST_POS;
					end
				end
				grs_pkg::ST_POS: begin
					col_q   <= CW'(col_n);
					row_q   <= row_n[grs_pkg::HEIGHT_W-1:0];
					state_q <= grs_pkg::ST_DIFF;
				end
				grs_pkg::ST_DIFF: begin
					prevpix_q <= pix_q;
					state_q   <= interior_q ? grs_pkg::ST_SQX : grs_pkg::ST_IDLE;
				end
				grs_pkg::ST_SQX: begin
					state_q <= grs_pkg::ST_SQY;
				end
				grs_pkg::ST_SQY: begin
					state_q <= grs_pkg::ST_SRCH;
				end
				grs_pkg::ST_SRCH: begin
					if (bit_q == 3'd0) begin
						state_q <= grs_pkg::ST_DONE;
					end
				end
				grs_pkg::ST_DONE: begin
					if (out_free) begin
						valid_out_q <= 1'b1;
						state_q     <= grs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= grs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == grs_pkg::ST_DONE && out_free) begin
			shade_q    <= k_q;
			last_out_q <= last_q;
		end
	end

endmodule
